// ===== rtl/vrcl_pkg.sv =====
// Package for the visible region clip list block.
// Holds sizes, request and result types, controller states, datapath ops and status flags.
// No dependencies.
package vrcl_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int EDGE_SLOTS  = 64;
    localparam int WIDX_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int WCNT_W      = $clog2(MAX_WINDOWS + 1);
    localparam int EIDX_W      = $clog2(EDGE_SLOTS);
    localparam int ECNT_W      = $clog2(EDGE_SLOTS + 1);
    localparam int CRD_W       = 12;
    localparam int EDG_W       = 14;
    localparam int RCT_W       = 13;
    localparam int BRD_W       = 6;

    typedef enum logic [1:0] {
        CMD_TARGET,
        CMD_ADD,
        CMD_FETCH,
        CMD_UNUSED
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [CRD_W-1:0] pos_x;
        logic [CRD_W-1:0] pos_y;
        logic [CRD_W-1:0] size_w;
        logic [CRD_W-1:0] size_h;
    } t_req;

    typedef struct packed {
        logic [RCT_W-1:0] rect_x;
        logic [RCT_W-1:0] rect_y;
        logic [CRD_W-1:0] rect_w;
        logic [CRD_W-1:0] rect_h;
        logic             done_res;
        logic             overflow;
    } t_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TGT0,
        ST_TGT1,
        ST_ADD0,
        ST_ADD1,
        ST_FETCH,
        ST_SRT_CHK,
        ST_SRT_WI,
        ST_SRT_J,
        ST_SRT_WJ,
        ST_ROW,
        ST_RY0,
        ST_RY1,
        ST_COL,
        ST_RX0,
        ST_RX1,
        ST_VIS1,
        ST_EXT,
        ST_RXE,
        ST_VIS2,
        ST_EMIT,
        ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TGT0,
        OP_TGT1,
        OP_ADD0,
        OP_ADD1,
        OP_SRT_INIT,
        OP_SRT_NEXT,
        OP_SRT_RDI,
        OP_SRT_LDV,
        OP_SRT_RDJ,
        OP_SRT_SHIFT,
        OP_SRT_PUT,
        OP_SCAN_INIT,
        OP_RDY0,
        OP_LDYA,
        OP_LDYB,
        OP_NEXTROW,
        OP_RDX0,
        OP_LDXA,
        OP_LDXB,
        OP_NEXTCOL,
        OP_VIS,
        OP_FOUND,
        OP_RDXE,
        OP_LDXC,
        OP_EXTOK,
        OP_EMIT,
        OP_DONE
    } t_op;

    typedef struct packed {
        logic srt_more;
        logic srt_sel;
        logic srt_j0;
        logic srt_gt;
        logic sorted;
        logic row_end;
        logic y_eq;
        logic col_end;
        logic x_eq_a;
        logic vis_end;
        logic visible;
        logic ext_end;
        logic x_eq_b;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/vrcl_ctrl.sv =====
// Controller state machine of the visible region clip list block.
// Sequences target setup, window adds, edge sorting and the grid scan.
// Depends on vrcl_pkg.
module vrcl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vrcl_pkg::t_cmd i_cmd,
    input  vrcl_pkg::t_sts i_sts,
    output logic           o_stall,
    output vrcl_pkg::t_op  o_op
);
    import vrcl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        CMD_TARGET: n_state = ST_TGT0;
                        CMD_ADD:    n_state = ST_ADD0;
                        CMD_FETCH:  n_state = ST_FETCH;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TGT0:  n_state = ST_TGT1;
            ST_TGT1:  n_state = ST_IDLE;
            ST_ADD0:  n_state = ST_ADD1;
            ST_ADD1:  n_state = ST_IDLE;
            ST_FETCH: n_state = i_sts.sorted ? ST_ROW : ST_SRT_CHK;
            ST_SRT_CHK: begin
                if (i_sts.srt_more) begin
                    n_state = ST_SRT_WI;
                end else if (!i_sts.srt_sel) begin
                    n_state = ST_SRT_CHK;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_SRT_WI: n_state = ST_SRT_J;
            ST_SRT_J:  n_state = i_sts.srt_j0 ? ST_SRT_CHK : ST_SRT_WJ;
            ST_SRT_WJ: n_state = i_sts.srt_gt ? ST_SRT_J : ST_SRT_CHK;
            ST_ROW:    n_state = i_sts.row_end ? ST_DONE : ST_RY0;
            ST_RY0:    n_state = ST_RY1;
            ST_RY1:    n_state = i_sts.y_eq ? ST_ROW : ST_COL;
            ST_COL:    n_state = i_sts.col_end ? ST_ROW : ST_RX0;
            ST_RX0:    n_state = ST_RX1;
            ST_RX1:    n_state = i_sts.x_eq_a ? ST_COL : ST_VIS1;
            ST_VIS1: begin
                if (i_sts.vis_end) begin
                    n_state = i_sts.visible ? ST_EXT : ST_COL;
                end
            end
            ST_EXT:    n_state = i_sts.ext_end ? ST_EMIT : ST_RXE;
            ST_RXE:    n_state = i_sts.x_eq_b ? ST_EMIT : ST_VIS2;
            ST_VIS2: begin
                if (i_sts.vis_end) begin
                    n_state = i_sts.visible ? ST_EXT : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_op    = OP_NONE;
        o_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_op = OP_LOAD;
                end
            end
            ST_TGT0:  o_op = OP_TGT0;
            ST_TGT1:  o_op = OP_TGT1;
            ST_ADD0:  o_op = OP_ADD0;
            ST_ADD1:  o_op = OP_ADD1;
            ST_FETCH: o_op = i_sts.sorted ? OP_NONE : OP_SRT_INIT;
            ST_SRT_CHK: begin
                if (i_sts.srt_more) begin
                    o_op = OP_SRT_RDI;
                end else if (!i_sts.srt_sel) begin
                    o_op = OP_SRT_NEXT;
                end else begin
                    o_op = OP_SCAN_INIT;
                end
            end
            ST_SRT_WI: o_op = OP_SRT_LDV;
            ST_SRT_J:  o_op = i_sts.srt_j0 ? OP_SRT_PUT : OP_SRT_RDJ;
            ST_SRT_WJ: o_op = i_sts.srt_gt ? OP_SRT_SHIFT : OP_SRT_PUT;
            ST_ROW:    o_op = i_sts.row_end ? OP_NONE : OP_RDY0;
            ST_RY0:    o_op = OP_LDYA;
            ST_RY1:    o_op = i_sts.y_eq ? OP_NEXTROW : OP_LDYB;
            ST_COL:    o_op = i_sts.col_end ? OP_NEXTROW : OP_RDX0;
            ST_RX0:    o_op = OP_LDXA;
            ST_RX1:    o_op = i_sts.x_eq_a ? OP_NEXTCOL : OP_LDXB;
            ST_VIS1: begin
                if (!i_sts.vis_end) begin
                    o_op = OP_VIS;
                end else begin
                    o_op = i_sts.visible ? OP_FOUND : OP_NEXTCOL;
                end
            end
            ST_EXT:    o_op = i_sts.ext_end ? OP_NONE : OP_RDXE;
            ST_RXE:    o_op = i_sts.x_eq_b ? OP_NONE : OP_LDXC;
            ST_VIS2: begin
                if (!i_sts.vis_end) begin
                    o_op = OP_VIS;
                end else begin
                    o_op = i_sts.visible ? OP_EXTOK : OP_NONE;
                end
            end
            ST_EMIT: o_op = i_sts.out_busy ? OP_NONE : OP_EMIT;
            ST_DONE: o_op = i_sts.out_busy ? OP_NONE : OP_DONE;
            default: o_op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/vrcl_dp.sv =====
// Datapath of the visible region clip list block.
// Holds target box, covering windows, edge memories, sort and scan registers.
// Depends on vrcl_pkg; driven by vrcl_ctrl ops.
module vrcl_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vrcl_pkg::t_op              i_op,
    input  vrcl_pkg::t_req             i_req,
    input  logic                       i_cfg_valid,
    input  logic [vrcl_pkg::BRD_W-1:0] i_cfg_data,
    input  logic                       i_stall,
    output vrcl_pkg::t_sts             o_sts,
    output logic                       o_valid,
    output vrcl_pkg::t_rsp             o_rsp
);
    import vrcl_pkg::*;

    logic [BRD_W-1:0]  r_border;
    t_req              r_req;
    logic [EDG_W-1:0]  r_tx0, r_ty0, r_tx1, r_ty1;
    logic [CRD_W-1:0]  r_orgx, r_orgy;
    logic [CRD_W-1:0]  r_cx0 [MAX_WINDOWS];
    logic [CRD_W-1:0]  r_cy0 [MAX_WINDOWS];
    logic [EDG_W-1:0]  r_cx1 [MAX_WINDOWS];
    logic [EDG_W-1:0]  r_cy1 [MAX_WINDOWS];
    logic [WCNT_W-1:0] r_cnt;
    logic [EDG_W-1:0]  r_xmem [EDGE_SLOTS];
    logic [EDG_W-1:0]  r_ymem [EDGE_SLOTS];
    logic [ECNT_W-1:0] r_nx, r_ny;
    logic              r_ovf, r_sorted, r_done, r_add_ok, r_sel, r_hidden;
    logic [ECNT_W-1:0] r_row, r_col, r_end, r_i, r_j;
    logic [WCNT_W-1:0] r_k;
    logic [EDG_W-1:0]  r_v, r_xrd, r_yrd, r_ya, r_yb, r_xa, r_xb, r_ax, r_bx;
    logic              r_out_valid;
    t_rsp              r_rsp;

    logic [EDG_W-1:0]  c_tx0, c_ty0, c_tx1, c_ty1, c_wx1, c_wy1, c_xe, c_ye;
    logic              c_wovl, c_take, c_xapp, c_yapp, c_xfull, c_yfull, c_kovl, c_room;
    logic              c_xwe, c_ywe;
    logic [EIDX_W-1:0] c_xwa, c_ywa, c_xra, c_yra;
    logic [EDG_W-1:0]  c_xwd, c_ywd;
    logic [ECNT_W-1:0] c_xr, c_yr;
    logic [WIDX_W-1:0] c_kidx;

    function automatic logic f_in_rng(input logic [EDG_W-1:0] v, input logic [EDG_W-1:0] lo,
                                      input logic [EDG_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    assign c_tx0  = EDG_W'(r_border) + EDG_W'(r_req.pos_x);
    assign c_ty0  = EDG_W'(r_border) + EDG_W'(r_req.pos_y);
    assign c_tx1  = c_tx0 + EDG_W'(r_req.size_w);
    assign c_ty1  = c_ty0 + EDG_W'(r_req.size_h);
    assign c_wx1  = EDG_W'(r_req.pos_x) + EDG_W'(r_req.size_w);
    assign c_wy1  = EDG_W'(r_req.pos_y) + EDG_W'(r_req.size_h);
    assign c_wovl = !(c_wx1 <= r_tx0 || r_tx1 <= EDG_W'(r_req.pos_x) ||
                      c_wy1 <= r_ty0 || r_ty1 <= EDG_W'(r_req.pos_y));
    assign c_room = (r_cnt < WCNT_W'(MAX_WINDOWS));
    assign c_xe   = (i_op == OP_ADD0) ? EDG_W'(r_req.pos_x) : c_wx1;
    assign c_ye   = (i_op == OP_ADD0) ? EDG_W'(r_req.pos_y) : c_wy1;
    assign c_take = (i_op == OP_ADD0) ? (c_room && c_wovl) : ((i_op == OP_ADD1) && r_add_ok);
    assign c_xapp = c_take && f_in_rng(c_xe, r_tx0, r_tx1);
    assign c_yapp = c_take && f_in_rng(c_ye, r_ty0, r_ty1);
    assign c_xfull = (r_nx >= ECNT_W'(EDGE_SLOTS));
    assign c_yfull = (r_ny >= ECNT_W'(EDGE_SLOTS));

    assign c_kidx = r_k[WIDX_W-1:0];
    assign c_kovl = !(r_cx1[c_kidx] <= r_ax || r_bx <= EDG_W'(r_cx0[c_kidx]) ||
                      r_cy1[c_kidx] <= r_ya || r_yb <= EDG_W'(r_cy0[c_kidx]));

    always_comb begin
        c_xwe = 1'b0;
        c_ywe = 1'b0;
        c_xwa = r_nx[EIDX_W-1:0];
        c_ywa = r_ny[EIDX_W-1:0];
        c_xwd = c_xe;
        c_ywd = c_ye;
        case (i_op)
            OP_TGT0: begin
                c_xwe = 1'b1;
                c_ywe = 1'b1;
                c_xwa = EIDX_W'(0);
                c_ywa = EIDX_W'(0);
                c_xwd = c_tx0;
                c_ywd = c_ty0;
            end
            OP_TGT1: begin
                c_xwe = 1'b1;
                c_ywe = 1'b1;
                c_xwa = EIDX_W'(1);
                c_ywa = EIDX_W'(1);
                c_xwd = r_tx1;
                c_ywd = r_ty1;
            end
            OP_ADD0, OP_ADD1: begin
                c_xwe = c_xapp && !c_xfull;
                c_ywe = c_yapp && !c_yfull;
            end
            OP_SRT_SHIFT: begin
                c_xwe = !r_sel;
                c_ywe = r_sel;
                c_xwa = r_j[EIDX_W-1:0];
                c_ywa = r_j[EIDX_W-1:0];
                c_xwd = r_xrd;
                c_ywd = r_yrd;
            end
            OP_SRT_PUT: begin
                c_xwe = !r_sel;
                c_ywe = r_sel;
                c_xwa = r_j[EIDX_W-1:0];
                c_ywa = r_j[EIDX_W-1:0];
                c_xwd = r_v;
                c_ywd = r_v;
            end
            default: begin
                c_xwe = 1'b0;
                c_ywe = 1'b0;
            end
        endcase
    end

    always_comb begin
        c_xr = r_col;
        c_yr = r_row;
        case (i_op)
            OP_LDXA:    c_xr = r_col + 1'b1;
            OP_RDXE:    c_xr = r_end + 1'b1;
            OP_LDYA:    c_yr = r_row + 1'b1;
            OP_SRT_RDI: begin
                c_xr = r_i;
                c_yr = r_i;
            end
            OP_SRT_RDJ: begin
                c_xr = r_j - 1'b1;
                c_yr = r_j - 1'b1;
            end
            default: begin
                c_xr = r_col;
                c_yr = r_row;
            end
        endcase
    end
    assign c_xra = c_xr[EIDX_W-1:0];
    assign c_yra = c_yr[EIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (c_xwe) begin
            r_xmem[c_xwa] <= c_xwd;
        end
        if (c_ywe) begin
            r_ymem[c_ywa] <= c_ywd;
        end
        r_xrd <= r_xmem[c_xra];
        r_yrd <= r_ymem[c_yra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border    <= '0;
            r_tx0       <= '0;
            r_ty0       <= '0;
            r_tx1       <= '0;
            r_ty1       <= '0;
            r_orgx      <= '0;
            r_orgy      <= '0;
            r_cnt       <= '0;
            r_nx        <= '0;
            r_ny        <= '0;
            r_ovf       <= 1'b0;
            r_sorted    <= 1'b0;
            r_done      <= 1'b0;
            r_add_ok    <= 1'b0;
            r_sel       <= 1'b0;
            r_hidden    <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_end       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_border <= i_cfg_data;
            end
            if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_op == OP_ADD0 || i_op == OP_ADD1) begin
                if (c_xapp) begin
                    if (c_xfull) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_nx <= r_nx + 1'b1;
                    end
                end
                if (c_yapp) begin
                    if (c_yfull) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_ny <= r_ny + 1'b1;
                    end
                end
            end
            case (i_op)
                OP_TGT0: begin
                    r_tx0    <= c_tx0;
                    r_ty0    <= c_ty0;
                    r_tx1    <= c_tx1;
                    r_ty1    <= c_ty1;
                    r_orgx   <= r_req.pos_x;
                    r_orgy   <= r_req.pos_y;
                    r_cnt    <= '0;
                    r_ovf    <= 1'b0;
                    r_sorted <= 1'b0;
                    r_done   <= 1'b0;
                    r_row    <= '0;
                    r_col    <= '0;
                end
                OP_TGT1: begin
                    r_nx <= ECNT_W'(2);
                    r_ny <= ECNT_W'(2);
                end
                OP_ADD0: begin
                    r_sorted <= 1'b0;
                    r_done   <= 1'b0;
                    r_row    <= '0;
                    r_col    <= '0;
                    if (!c_room) begin
                        r_ovf    <= 1'b1;
                        r_add_ok <= 1'b0;
                    end else begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_add_ok <= c_wovl;
                    end
                end
                OP_SRT_INIT: begin
                    r_sel <= 1'b0;
                    r_i   <= ECNT_W'(1);
                end
                OP_SRT_NEXT: begin
                    r_sel <= 1'b1;
                    r_i   <= ECNT_W'(1);
                end
                OP_SRT_RDI:   r_j <= r_i;
                OP_SRT_SHIFT: r_j <= r_j - 1'b1;
                OP_SRT_PUT:   r_i <= r_i + 1'b1;
                OP_SCAN_INIT: begin
                    r_row    <= '0;
                    r_col    <= '0;
                    r_sorted <= 1'b1;
                end
                OP_NEXTROW: begin
                    r_row <= r_row + 1'b1;
                    r_col <= '0;
                end
                OP_NEXTCOL: r_col <= r_col + 1'b1;
                OP_LDXB, OP_LDXC: begin
                    r_k      <= '0;
                    r_hidden <= 1'b0;
                end
                OP_VIS: begin
                    if (c_kovl) begin
                        r_hidden <= 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                end
                OP_FOUND: r_end <= r_col + 1'b1;
                OP_EXTOK: r_end <= r_end + 1'b1;
                OP_EMIT: begin
                    r_col       <= r_end;
                    r_out_valid <= 1'b1;
                end
                OP_DONE: begin
                    r_done      <= 1'b1;
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD:    r_req <= i_req;
            OP_ADD0: begin
                if (c_room) begin
                    r_cx0[r_cnt[WIDX_W-1:0]] <= r_req.pos_x;
                    r_cy0[r_cnt[WIDX_W-1:0]] <= r_req.pos_y;
                    r_cx1[r_cnt[WIDX_W-1:0]] <= c_wx1;
                    r_cy1[r_cnt[WIDX_W-1:0]] <= c_wy1;
                end
            end
            OP_SRT_LDV: r_v  <= r_sel ? r_yrd : r_xrd;
            OP_LDYA:    r_ya <= r_yrd;
            OP_LDYB:    r_yb <= r_yrd;
            OP_LDXA:    r_xa <= r_xrd;
            OP_LDXB: begin
                r_xb <= r_xrd;
                r_ax <= r_xa;
                r_bx <= r_xrd;
            end
            OP_LDXC: begin
                r_ax <= r_xb;
                r_bx <= r_xrd;
            end
            OP_EXTOK:   r_xb <= r_bx;
            OP_EMIT: begin
                r_rsp.rect_x   <= RCT_W'(r_xa - EDG_W'(r_orgx));
                r_rsp.rect_y   <= RCT_W'(r_ya - EDG_W'(r_orgy));
                r_rsp.rect_w   <= CRD_W'(r_xb - r_xa);
                r_rsp.rect_h   <= CRD_W'(r_yb - r_ya);
                r_rsp.done_res <= 1'b0;
                r_rsp.overflow <= r_ovf;
            end
            OP_DONE: begin
                r_rsp.rect_x   <= '0;
                r_rsp.rect_y   <= '0;
                r_rsp.rect_w   <= '0;
                r_rsp.rect_h   <= '0;
                r_rsp.done_res <= 1'b1;
                r_rsp.overflow <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.srt_more = (r_i < (r_sel ? r_ny : r_nx));
    assign o_sts.srt_sel  = r_sel;
    assign o_sts.srt_j0   = (r_j == '0);
    assign o_sts.srt_gt   = ((r_sel ? r_yrd : r_xrd) > r_v);
    assign o_sts.sorted   = r_sorted;
    assign o_sts.row_end  = r_done || (r_row + 1'b1 >= r_ny);
    assign o_sts.y_eq     = (r_yrd == r_ya);
    assign o_sts.col_end  = (r_col + 1'b1 >= r_nx);
    assign o_sts.x_eq_a   = (r_xrd == r_xa);
    assign o_sts.vis_end  = r_hidden || (r_k >= r_cnt);
    assign o_sts.visible  = !r_hidden;
    assign o_sts.ext_end  = (r_end + 1'b1 >= r_nx);
    assign o_sts.x_eq_b   = (r_xrd == r_xb);
    assign o_sts.out_busy = r_out_valid && i_stall;

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    a_edge_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nx <= ECNT_W'(EDGE_SLOTS)) && (r_ny <= ECNT_W'(EDGE_SLOTS)))
        else $error("edge count beyond capacity");

    a_win_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= WCNT_W'(MAX_WINDOWS))
        else $error("window count beyond capacity");

    a_tgt_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_TGT1) |=> (r_nx == ECNT_W'(2) && r_ny == ECNT_W'(2) && r_cnt == '0))
        else $error("target setup left stale lists");

    a_emit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_EMIT) |-> (!r_done && r_sorted))
        else $error("rectangle emitted from a finished or unsorted scan");

endmodule

// ===== rtl/visible_region_clip_list_top.sv =====
// Top level of the visible region clip list block.
// Joins vrcl_ctrl and vrcl_dp; depends on vrcl_pkg.
//
//  channel  | valid        | flow control  | payload
//  ---------+--------------+---------------+------------------------
//  request  | i_valid      | o_stall       | i_req (vrcl_pkg::t_req)
//  result   | o_valid      | i_stall       | o_rsp (vrcl_pkg::t_rsp)
//  config   | i_cfg_valid  | o_cfg_ready   | i_cfg_data (border offset)
//
// Set target steps through ST_TGT0 and ST_TGT1, add window through ST_ADD0 and
// ST_ADD1; an unused command is dropped while idle. Fetch: an insertion sort of
// both edge lists on the first fetch after a target or window change, then a grid
// scan in which each patch is tested against the stored windows in turn.
// Reset clears all control state; edge and window stores need no clearing.
// A waiting result does not block a new request; a result stalls only the next.
module visible_region_clip_list_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  vrcl_pkg::t_req             i_req,
    output logic                       o_valid,
    input  logic                       i_stall,
    output vrcl_pkg::t_rsp             o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [vrcl_pkg::BRD_W-1:0] i_cfg_data
);
    import vrcl_pkg::*;

    t_op  w_op;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    vrcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_req.cmd),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_op    (w_op)
    );

    vrcl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

endmodule
